/* sv/elh_pkg.sv */
// Package with the types, codes and defaults shared by the light level filter.
`timescale 1ns / 1ps
`default_nettype none

package elh_pkg;

  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned MaxShiftDefault   = 6;

  localparam int unsigned AccBits   = 32;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned LevelBits = 16;
  localparam int unsigned ShiftBits = 3;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ZONE_DARK   = 2'd0,
    ZONE_GAP    = 2'd1,
    ZONE_BRIGHT = 2'd2
  } zone_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BRIGHT_TO_DARK = 2'd0,
    CFG_DARK_TO_BRIGHT = 2'd1,
    CFG_FILTER_SHIFT   = 2'd2,
    CFG_INTERVAL       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelBits-1:0] bright_to_dark_level;
    logic [LevelBits-1:0] dark_to_bright_level;
    logic [ShiftBits-1:0] filter_shift;
    logic [15:0]          sample_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [LevelBits-1:0] filtered_level;
    zone_e                zone;
    logic                 light_state;
    logic                 sample_taken;
  } result_t;

  localparam logic [LevelBits-1:0] BrightToDarkReset = 16'd1000;
  localparam logic [LevelBits-1:0] DarkToBrightReset = 16'd1500;
  localparam logic [ShiftBits-1:0] FilterShiftReset  = 3'd4;
  localparam logic [15:0]          IntervalReset     = 16'd100;

endpackage

`default_nettype wire

/* sv/elh_cfg_regs.sv */
// Configuration register file of the light level filter.
`timescale 1ns / 1ps
`default_nettype none

module elh_cfg_regs
  import elh_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHT_TO_DARK: cfg_d.bright_to_dark_level = cfg_wdata_i;
        CFG_DARK_TO_BRIGHT: cfg_d.dark_to_bright_level = cfg_wdata_i;
        CFG_FILTER_SHIFT:   cfg_d.filter_shift = cfg_wdata_i[ShiftBits-1:0];
        CFG_INTERVAL:       cfg_d.sample_interval_ms = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_to_dark_level <= BrightToDarkReset;
      cfg_q.dark_to_bright_level <= DarkToBrightReset;
      cfg_q.filter_shift         <= FilterShiftReset;
      cfg_q.sample_interval_ms   <= IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/elh_filter.sv */
// Filter state, moving average update and hysteresis classification.
`timescale 1ns / 1ps
`default_nettype none

module elh_filter
  import elh_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault,
  parameter int unsigned MAX_SHIFT   = MaxShiftDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  op_e                         op_i,
  input  wire logic [TimeBits-1:0]    now_ms_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  cfg_t                        cfg_i,
  output result_t                     result_o
);

  localparam int unsigned ShW = ($clog2(2 * MAX_SHIFT + 1) > ShiftBits + 1) ?
                                $clog2(2 * MAX_SHIFT + 1) : ShiftBits + 1;
  localparam logic [ShW-1:0] MaxShift = ShW'(MAX_SHIFT);
  localparam logic [ShW-1:0] MinShift = ShW'(1);

  logic [AccBits-1:0]  acc_q, acc_d;
  logic [TimeBits-1:0] last_time_q, last_time_d;
  logic                seeded_q, seeded_d;
  logic                light_q, light_d;

  logic [ShW-1:0]       shift;
  logic [ShW-1:0]       shift2;
  logic [AccBits-1:0]   sample_ext;
  logic [TimeBits-1:0]  elapsed;
  logic                 take;
  logic [AccBits-1:0]   acc_new;
  logic [LevelBits-1:0] level;
  zone_e                zone;

  always_comb begin
    if (cfg_i.filter_shift == '0) begin
      shift = MinShift;
    end else if (ShW'(cfg_i.filter_shift) > MaxShift) begin
      shift = MaxShift;
    end else begin
      shift = ShW'(cfg_i.filter_shift);
    end
  end

  assign shift2     = ShW'(shift << 1);
  assign sample_ext = AccBits'(sample_i);
  assign elapsed    = now_ms_i - last_time_q;

  always_comb begin
    take    = 1'b0;
    acc_new = acc_q;
    if (op_i == OP_SEED) begin
      take    = 1'b1;
      acc_new = sample_ext << shift2;
    end else if (elapsed >= TimeBits'(cfg_i.sample_interval_ms) || !seeded_q) begin
      take    = 1'b1;
      acc_new = acc_q - (acc_q >> shift) + (sample_ext << shift);
    end
  end

  assign level = LevelBits'(acc_new >> shift2);

  always_comb begin
    if (level > cfg_i.dark_to_bright_level) begin
      zone = ZONE_BRIGHT;
    end else if (level < cfg_i.bright_to_dark_level) begin
      zone = ZONE_DARK;
    end else begin
      zone = ZONE_GAP;
    end
  end

  always_comb begin
    light_d = light_q;
    if (op_i == OP_READ) begin
      case (zone)
        ZONE_BRIGHT: light_d = 1'b1;
        ZONE_DARK:   light_d = 1'b0;
        default:     light_d = light_q;
      endcase
    end
  end

  assign acc_d       = take ? acc_new : acc_q;
  assign last_time_d = take ? now_ms_i : last_time_q;
  assign seeded_d    = seeded_q | take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      last_time_q <= '0;
      seeded_q    <= 1'b0;
      light_q     <= 1'b0;
    end else if (advance_i) begin
      acc_q       <= acc_d;
      last_time_q <= last_time_d;
      seeded_q    <= seeded_d;
      light_q     <= light_d;
    end
  end

  assign result_o.filtered_level = level;
  assign result_o.zone           = zone;
  assign result_o.light_state    = light_d;
  assign result_o.sample_taken   = take;

endmodule

`default_nettype wire

/* sv/ema_light_level_hysteresis.sv */
// Top level of the smoothed light level detector with hysteresis.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one transaction per cycle unless stalled and returns one
// result per transaction: an input register holds it, the filter update
// and threshold compares run in one pass, and a result register presents
// the outcome. The output stall reaches the input stall through one gate
// when both registers are full. The user must write configuration through
// a plain write port while idle; the block itself does not enforce this.

module ema_light_level_hysteresis
  import elh_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault,
  parameter int unsigned MAX_SHIFT   = MaxShiftDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   op_i,
  input  wire logic [TimeBits-1:0]    now_ms_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [LevelBits-1:0]        filtered_level_o,
  output logic [1:0]                  zone_o,
  output logic                        light_state_o,
  output logic                        sample_taken_o
);

  cfg_t    cfg;
  result_t result;

  logic                   in_valid_q;
  op_e                    op_q;
  logic [TimeBits-1:0]    now_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   out_valid_q;
  result_t                out_q;
  logic                   advance;
  logic                   in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  elh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  elh_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SHIFT   (MAX_SHIFT)
  ) u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .op_i      (op_q),
    .now_ms_i  (now_q),
    .sample_i  (sample_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= op_e'(op_i);
      now_q    <= now_ms_i;
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_level_o = out_q.filtered_level;
  assign zone_o           = out_q.zone;
  assign light_state_o    = out_q.light_state;
  assign sample_taken_o   = out_q.sample_taken;

endmodule

`default_nettype wire

/* sv/elh_checker.sv */
// Port level checks for the light level detector and their binding.
`timescale 1ns / 1ps
`default_nettype none

module elh_checker
  import elh_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [LevelBits-1:0] filtered_level_o,
  input wire logic [1:0]           zone_o,
  input wire logic                 light_state_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(filtered_level_o) && $stable(zone_o)
      && $stable(light_state_o))
    else $error("Result payload changed while stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled result.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("Accepted transaction produced no result in time.");

endmodule

bind ema_light_level_hysteresis elh_checker u_elh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_level_o (filtered_level_o),
  .zone_o           (zone_o),
  .light_state_o    (light_state_o)
);

`default_nettype wire
